// ===== hdl/irts_pkg.sv =====
// Package for the I2C register transaction sequencer.
// Holds the transfer structs, the queue entry type, the state enum and the code constants.
// Depends on nothing; the top level, the sequencer and the checker refer to it by scoped names.
package irts_pkg;

  // Command codes of an input transfer.
  localparam logic [1:0] CMD_ENQ_READ  = 2'd0;
  localparam logic [1:0] CMD_ENQ_WRITE = 2'd1;
  localparam logic [1:0] CMD_BUS_EVENT = 2'd2;

  // Bus event codes reported by the I2C master.
  localparam logic [2:0] EV_START_SENT = 3'd0;
  localparam logic [2:0] EV_RX_MODE    = 3'd1;
  localparam logic [2:0] EV_TX_MODE    = 3'd2;
  localparam logic [2:0] EV_TX_DONE    = 3'd4;
  localparam logic [2:0] EV_RX_DONE    = 3'd5;

  // Actions requested from the I2C master.
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_START    = 3'd1;
  localparam logic [2:0] ACT_ADDR_WR  = 3'd2;
  localparam logic [2:0] ACT_ADDR_RD  = 3'd3;
  localparam logic [2:0] ACT_SEND     = 3'd4;
  localparam logic [2:0] ACT_STOP     = 3'd5;
  localparam logic [2:0] ACT_ARM_NACK = 3'd6;

  // One input transfer.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] device_address;
    logic [7:0] register_index;
    logic [7:0] write_byte;
    logic [2:0] bus_event;
    logic [7:0] received_byte;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] action_byte;
    logic       restart_after;
    logic       read_valid;
    logic [7:0] read_data;
    logic       request_rejected;
  } out_item_t;

  // One queued request as it is stored in the queue memory.
  typedef struct packed {
    logic       is_write;
    logic [7:0] device_address;
    logic [7:0] register_index;
    logic [7:0] write_byte;
  } entry_t;

  // Sequencer control states.
  typedef enum logic {
    SEQ_IDLE,
    SEQ_EXEC
  } seq_state_t;

endpackage

// ===== hdl/i2c_register_transaction_sequencer_top.sv =====
// An accepted transfer and the head request, read from the queue memory through its registered
// read port, are registered; the decision runs in the execute state and the result is registered
// with its strobe. busy is high for one cycle, the execute state; no transfer is taken while busy.
// Reset is synchronous and active low: it clears the queue pointers, count, phase and strobe.
// Queue contents are not cleared and need no clearing pass. The receiver cannot stall.
// Depends on irts_pkg, irts_ram and irts_seq.
module i2c_register_transaction_sequencer_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  irts_pkg::in_item_t  in_item,
  output logic                out_valid,
  output irts_pkg::out_item_t out_item
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  irts_pkg::entry_t ram_wdata;
  irts_pkg::entry_t ram_rdata;

  // Request queue storage.
  irts_ram #(
    .WIDTH($bits(irts_pkg::entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Transaction sequencer.
  irts_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== hdl/irts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the request queue; depends on nothing.
module irts_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/irts_seq.sv =====
// Sequencer for the I2C register transaction queue: pointers, count, phase and decisions.
// Reads the head request from the queue memory and writes new requests at the tail.
// Depends on irts_pkg.
module irts_seq #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  irts_pkg::in_item_t             in_item,
  output logic                           ram_re,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
  output logic                           ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
  output irts_pkg::entry_t               ram_wdata,
  input  irts_pkg::entry_t               ram_rdata,
  output logic                           out_valid,
  output irts_pkg::out_item_t            out_item
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  irts_pkg::seq_state_t state_r, state_nxt;
  irts_pkg::in_item_t   req_r;
  logic [AW-1:0]        head_r, head_nxt;
  logic [AW-1:0]        tail_r, tail_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 phase_r, phase_nxt;
  logic                 out_valid_r;
  irts_pkg::out_item_t  out_item_r, out_item_nxt;
  logic                 accept;
  logic                 exec;
  logic                 enq_we;
  logic                 q_write;
  logic                 q_read_ph2;

  assign accept = start && !busy;

  // Next state: a start in idle moves to the execute state, which always returns to idle.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      irts_pkg::SEQ_IDLE: begin
        if (start) begin
          state_nxt = irts_pkg::SEQ_EXEC;
        end
      end
      irts_pkg::SEQ_EXEC: begin
        state_nxt = irts_pkg::SEQ_IDLE;
      end
      default: begin
        state_nxt = irts_pkg::SEQ_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    case (state_r)
      irts_pkg::SEQ_IDLE: begin
        busy = 1'b0;
        exec = 1'b0;
      end
      irts_pkg::SEQ_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: begin
        busy = 1'b0;
        exec = 1'b0;
      end
    endcase
  end

  // The head entry is fetched in the cycle the transfer is accepted.
  assign ram_re    = accept;
  assign ram_raddr = head_r;

  // New requests go in at the tail.
  assign ram_we    = enq_we;
  assign ram_waddr = tail_r;
  assign ram_wdata = '{
    is_write:       (req_r.command == irts_pkg::CMD_ENQ_WRITE),
    device_address: req_r.device_address,
    register_index: req_r.register_index,
    write_byte:     req_r.write_byte
  };

  assign q_write    = ram_rdata.is_write;
  assign q_read_ph2 = !ram_rdata.is_write && phase_r;

  // Decision logic: runs on the held transfer and the fetched head entry.
  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    phase_nxt    = phase_r;
    enq_we       = 1'b0;
    out_item_nxt = '0;
    if (exec) begin
      case (req_r.command)
        irts_pkg::CMD_ENQ_READ, irts_pkg::CMD_ENQ_WRITE: begin
          if (count_r == CW'(QUEUE_DEPTH)) begin
            out_item_nxt.request_rejected = 1'b1;
          end else begin
            enq_we    = 1'b1;
            tail_nxt  = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
            count_nxt = count_r + 1'b1;
            if (count_r == '0) begin
              out_item_nxt.bus_action = irts_pkg::ACT_START;
            end
          end
        end
        irts_pkg::CMD_BUS_EVENT: begin
          if (count_r != '0) begin
            case (req_r.bus_event)
              irts_pkg::EV_START_SENT: begin
                if (q_read_ph2) begin
                  out_item_nxt.bus_action  = irts_pkg::ACT_ADDR_RD;
                  out_item_nxt.action_byte = ram_rdata.device_address | 8'h01;
                end else begin
                  out_item_nxt.bus_action  = irts_pkg::ACT_ADDR_WR;
                  out_item_nxt.action_byte = ram_rdata.device_address & 8'hFE;
                end
              end
              irts_pkg::EV_RX_MODE: begin
                if (q_read_ph2) begin
                  out_item_nxt.bus_action = irts_pkg::ACT_ARM_NACK;
                end
              end
              irts_pkg::EV_TX_MODE: begin
                if (!phase_r) begin
                  out_item_nxt.bus_action  = irts_pkg::ACT_SEND;
                  out_item_nxt.action_byte = ram_rdata.register_index;
                end else if (q_write) begin
                  out_item_nxt.bus_action  = irts_pkg::ACT_SEND;
                  out_item_nxt.action_byte = ram_rdata.write_byte;
                end
              end
              irts_pkg::EV_TX_DONE: begin
                if (!phase_r) begin
                  out_item_nxt.bus_action = irts_pkg::ACT_START;
                  phase_nxt               = 1'b1;
                end else if (q_write) begin
                  // Write finished: stop and drop the head request.
                  out_item_nxt.bus_action    = irts_pkg::ACT_STOP;
                  out_item_nxt.restart_after = (count_r != CW'(1));
                  head_nxt  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
                  count_nxt = count_r - 1'b1;
                  phase_nxt = 1'b0;
                end
              end
              irts_pkg::EV_RX_DONE: begin
                if (q_read_ph2) begin
                  // Read finished: hand back the byte and drop the head request.
                  out_item_nxt.bus_action    = irts_pkg::ACT_STOP;
                  out_item_nxt.read_valid    = 1'b1;
                  out_item_nxt.read_data     = req_r.received_byte;
                  out_item_nxt.restart_after = (count_r != CW'(1));
                  head_nxt  = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
                  count_nxt = count_r - 1'b1;
                  phase_nxt = 1'b0;
                end
              end
              default: begin
                out_item_nxt = '0;
              end
            endcase
          end
        end
        default: begin
          out_item_nxt = '0;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= irts_pkg::SEQ_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= exec;
    end
  end

  // Payload registers: the held transfer and the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item;
    end
    if (exec) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/irts_checker.sv =====
// Port-level checker for the I2C register transaction sequencer, with its bind statement.
// Depends on irts_pkg and on the top level's ports.
module irts_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input irts_pkg::out_item_t out_item
);

  // An accepted transfer makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  // A busy cycle ends with exactly one result and the block free again.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("busy cycle did not produce a result");

  // No result without a preceding busy cycle.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transfer");

  // A rejected request causes no bus action and no read data.
  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.request_rejected) |->
      (out_item.bus_action == irts_pkg::ACT_NONE && !out_item.read_valid))
    else $error("rejected request produced an action");

  // A completed read always comes with a stop.
  a_read_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.read_valid) |-> (out_item.bus_action == irts_pkg::ACT_STOP))
    else $error("read data without stop");

endmodule

bind i2c_register_transaction_sequencer_top irts_checker u_irts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
